FILE: design/shic_pkg.sv
package shic_pkg;

    // Field widths
    localparam int unsigned CODE_W  = 12;
    localparam int unsigned IDLE_W  = 16;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned ALERT_W = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned KEY_W   = 3;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_BAND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAVED_SP  = 3'd5;

    // Register reset values
    localparam logic [CODE_W-1:0]  RST_CURRENT_LIMIT = 12'd4095;
    localparam logic [CODE_W-1:0]  RST_STABLE_BAND   = 12'd25;
    localparam logic [IDLE_W-1:0]  RST_IDLE_TICKS    = 16'd600;
    localparam logic [ALERT_W-1:0] RST_ALERT_TICKS   = 8'd6;
    localparam logic [DUTY_W-1:0]  RST_MAX_DUTY      = 8'd200;
    localparam logic [CODE_W-1:0]  RST_MAX_SAVED_SP  = 12'd600;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd2;

    // Keys
    localparam logic [KEY_W-1:0] KEY_NONE  = 3'd0;
    localparam logic [KEY_W-1:0] KEY_SLEEP = 3'd1;
    localparam logic [KEY_W-1:0] KEY_MODE  = 3'd2;
    localparam logic [KEY_W-1:0] KEY_UP    = 3'd3;
    localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd4;

    // Saturation limits
    localparam logic [CODE_W-1:0] SETPOINT_MAX = {CODE_W{1'b1}};
    localparam logic [IDLE_W-1:0] IDLE_MAX     = {IDLE_W{1'b1}};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] current_code;
        logic [CODE_W-1:0] temp_code;
        logic [CODE_W-1:0] saved_setpoint;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              heating_lamp;
        logic              relay_closed;
        logic              alarm;
        logic              awake;
        logic              setting_mode;
        logic [CODE_W-1:0] setpoint;
        logic              tripped;
    } t_out_item;

    typedef struct packed {
        logic [CODE_W-1:0]  current_limit_code;
        logic [CODE_W-1:0]  stable_band_code;
        logic [IDLE_W-1:0]  idle_ticks;
        logic [ALERT_W-1:0] alert_ticks;
        logic [DUTY_W-1:0]  max_duty;
        logic [CODE_W-1:0]  max_saved_setpoint;
    } t_cfg;

endpackage

FILE: design/shic_in_if.sv
interface shic_in_if;
    logic               valid;
    logic               ready;
    shic_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/shic_out_if.sv
interface shic_out_if;
    logic                valid;
    logic                ready;
    shic_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/soldering_iron_heater_controller.sv
// A beat accepted is held in the input register, then passes through the combinational update
// into the result register, which drives the result channel.
// Throughput: one item per cycle; a stalled result holds the input register, and input
// ready drops once both registers are full and the result is stalled.
// The rate is set by the input register feeding one combinational update into the result register.
// Reset (synchronous, active low) restores the register defaults and the controller state:
// awake, setpoint zero, no trip, no alarm; both pipeline registers empty.
module soldering_iron_heater_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    shic_in_if.sink                             i_item,
    shic_out_if.source                          o_result,
    input  logic                                i_cfg_we,
    input  logic [shic_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [shic_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    shic_pkg::t_cfg      cfg;
    shic_pkg::t_in_item  r_in;
    shic_pkg::t_out_item r_out;
    shic_pkg::t_out_item result;
    logic                r_in_vld;
    logic                r_out_vld;
    logic                adv;

    shic_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Advance the held beat when the result register is free or being drained
    assign adv          = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_item.ready = !r_in_vld || adv;

    shic_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_result (result)
    );

    // Valid flags of the input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_vld <= i_item.valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in <= i_item.data;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

endmodule

FILE: design/shic_cfg.sv
module shic_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  logic [shic_pkg::CFG_IDX_W-1:0]       i_idx,
    input  logic [shic_pkg::CFG_DATA_W-1:0]      i_data,
    output shic_pkg::t_cfg                       o_cfg
);

    shic_pkg::t_cfg r_cfg;

    // Decode the index and load the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_limit_code <= shic_pkg::RST_CURRENT_LIMIT;
            r_cfg.stable_band_code   <= shic_pkg::RST_STABLE_BAND;
            r_cfg.idle_ticks         <= shic_pkg::RST_IDLE_TICKS;
            r_cfg.alert_ticks        <= shic_pkg::RST_ALERT_TICKS;
            r_cfg.max_duty           <= shic_pkg::RST_MAX_DUTY;
            r_cfg.max_saved_setpoint <= shic_pkg::RST_MAX_SAVED_SP;
        end else if (i_we) begin
            unique case (i_idx)
                shic_pkg::CFG_CURRENT_LIMIT:
                    r_cfg.current_limit_code <= i_data[shic_pkg::CODE_W-1:0];
                shic_pkg::CFG_STABLE_BAND:
                    r_cfg.stable_band_code <= i_data[shic_pkg::CODE_W-1:0];
                shic_pkg::CFG_IDLE_TICKS:
                    r_cfg.idle_ticks <= i_data[shic_pkg::IDLE_W-1:0];
                shic_pkg::CFG_ALERT_TICKS:
                    r_cfg.alert_ticks <= i_data[shic_pkg::ALERT_W-1:0];
                shic_pkg::CFG_MAX_DUTY:
                    r_cfg.max_duty <= i_data[shic_pkg::DUTY_W-1:0];
                shic_pkg::CFG_MAX_SAVED_SP:
                    r_cfg.max_saved_setpoint <= i_data[shic_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/shic_core.sv
module shic_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  shic_pkg::t_cfg       i_cfg,
    input  shic_pkg::t_in_item   i_item,
    output shic_pkg::t_out_item  o_result
);

    localparam int unsigned CW = shic_pkg::CODE_W;
    localparam int unsigned IW = shic_pkg::IDLE_W;
    localparam int unsigned DW = shic_pkg::DUTY_W;

    logic          r_awake, n_awake;
    logic          r_mode, n_mode;
    logic [CW-1:0] r_setpoint, n_setpoint;
    logic          r_trip, n_trip;
    logic [CW-1:0] r_latest, n_latest;
    logic [CW-1:0] r_ref, n_ref;
    logic [IW-1:0] r_idle, n_idle;
    logic          r_alarm, n_alarm;
    logic [DW-1:0] r_duty, n_duty;
    logic          r_lamp, n_lamp;

    logic [CW-1:0] cur_diff;
    logic          stable;
    logic [IW-1:0] idle_inc;
    logic [IW-1:0] idle_cnt;
    logic [IW-1:0] idle_cnt_inc;
    logic [IW:0]   alert_end_cnt;
    logic          alert_end;
    logic          sleep_due;
    logic [CW-1:0] heat_err;

    // Idle detector: current drift since the last stable tick
    assign cur_diff = (r_ref > r_latest) ? (r_ref - r_latest) : (r_latest - r_ref);
    assign stable   = r_awake && (cur_diff < i_cfg.stable_band_code);
    assign idle_inc = (r_idle != shic_pkg::IDLE_MAX) ? (r_idle + 1'b1) : r_idle;
    assign idle_cnt = stable ? idle_inc : r_idle;
    assign idle_cnt_inc = (idle_cnt != shic_pkg::IDLE_MAX) ? (idle_cnt + 1'b1) : idle_cnt;
    assign alert_end_cnt = {1'b0, i_cfg.idle_ticks}
                         + {{(IW+1-shic_pkg::ALERT_W){1'b0}}, i_cfg.alert_ticks};
    assign sleep_due = idle_cnt > i_cfg.idle_ticks;
    assign alert_end = ({1'b0, idle_cnt} > alert_end_cnt)
                    || ((idle_cnt == shic_pkg::IDLE_MAX) && sleep_due);

    // Next state for one item
    always_comb begin
        n_awake    = r_awake;
        n_mode     = r_mode;
        n_setpoint = r_setpoint;
        n_trip     = r_trip;
        n_latest   = r_latest;
        n_ref      = r_ref;
        n_idle     = r_idle;
        n_alarm    = r_alarm;
        n_duty     = r_duty;
        n_lamp     = r_lamp;
        heat_err   = '0;

        if (!r_trip) begin
            unique case (i_item.kind)
                shic_pkg::KIND_SAMPLE: begin
                    // Apply the key first
                    unique case (i_item.key)
                        shic_pkg::KEY_SLEEP: n_awake = ~r_awake;
                        shic_pkg::KEY_MODE:  n_mode  = ~r_mode;
                        shic_pkg::KEY_UP: begin
                            if (r_setpoint != shic_pkg::SETPOINT_MAX) begin
                                n_setpoint = r_setpoint + 1'b1;
                            end
                        end
                        shic_pkg::KEY_DOWN: begin
                            if (r_setpoint != '0) begin
                                n_setpoint = r_setpoint - 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    n_latest = i_item.current_code;
                    heat_err = n_setpoint - i_item.temp_code;

                    // Latch overcurrent, else regulate
                    if (i_item.current_code > i_cfg.current_limit_code) begin
                        n_trip = 1'b1;
                    end else if (!n_awake || (i_item.temp_code > n_setpoint)) begin
                        n_duty = '0;
                        n_lamp = 1'b0;
                    end else begin
                        if (heat_err > {{(CW-DW){1'b0}}, i_cfg.max_duty}) begin
                            n_duty = i_cfg.max_duty;
                        end else begin
                            n_duty = heat_err[DW-1:0];
                        end
                        n_lamp = 1'b1;
                    end
                end
                shic_pkg::KIND_TICK: begin
                    if (stable) begin
                        n_ref = r_latest;
                    end
                    if (alert_end) begin
                        n_idle  = '0;
                        n_alarm = 1'b0;
                    end else if (sleep_due) begin
                        n_idle     = idle_cnt_inc;
                        n_alarm    = 1'b1;
                        n_setpoint = '0;
                        n_awake    = 1'b0;
                        n_duty     = '0;
                        n_lamp     = 1'b0;
                    end else begin
                        n_idle = idle_cnt;
                    end
                end
                shic_pkg::KIND_RESTORE: begin
                    n_setpoint = (i_item.saved_setpoint > i_cfg.max_saved_setpoint)
                               ? '0 : i_item.saved_setpoint;
                end
                default: ;
            endcase
        end
    end

    // Commit state when an item passes through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awake    <= 1'b1;
            r_mode     <= 1'b0;
            r_setpoint <= '0;
            r_trip     <= 1'b0;
            r_latest   <= '0;
            r_ref      <= '0;
            r_idle     <= '0;
            r_alarm    <= 1'b0;
            r_duty     <= '0;
            r_lamp     <= 1'b0;
        end else if (i_en) begin
            r_awake    <= n_awake;
            r_mode     <= n_mode;
            r_setpoint <= n_setpoint;
            r_trip     <= n_trip;
            r_latest   <= n_latest;
            r_ref      <= n_ref;
            r_idle     <= n_idle;
            r_alarm    <= n_alarm;
            r_duty     <= n_duty;
            r_lamp     <= n_lamp;
        end
    end

    // Status beat from the updated state; a trip overrides the heater outputs
    always_comb begin
        o_result.duty         = n_trip ? '0 : n_duty;
        o_result.heating_lamp = n_trip ? 1'b0 : n_lamp;
        o_result.relay_closed = ~n_trip;
        o_result.alarm        = n_trip | n_alarm;
        o_result.awake        = n_awake;
        o_result.setting_mode = n_mode;
        o_result.setpoint     = n_setpoint;
        o_result.tripped      = n_trip;
    end

endmodule
